// ===== rtl/spd_pkg.sv =====
// Package for the serial packet deframer: parse phases, status codes and byte constants.
`default_nettype none

package spd_pkg;

    // Frame parse phases, one per field of the frame.
    typedef enum logic [3:0] {
        PH_SYNC1   = 4'd0,
        PH_SYNC2   = 4'd1,
        PH_LEN_LO  = 4'd2,
        PH_LEN_HI  = 4'd3,
        PH_LEN_CHK = 4'd4,
        PH_INST    = 4'd5,
        PH_DEV_ID  = 4'd6,
        PH_PAYLOAD = 4'd7,
        PH_CSUM    = 4'd8
    } phase_t;

    // Per-word frame status codes.
    localparam logic [1:0] ST_BUSY    = 2'd0;
    localparam logic [1:0] ST_OK      = 2'd1;
    localparam logic [1:0] ST_LEN_ERR = 2'd2;
    localparam logic [1:0] ST_SUM_ERR = 2'd3;

    localparam logic [7:0] SYNC_BYTE = 8'hFF;

endpackage : spd_pkg

`default_nettype wire

// ===== rtl/serial_packet_deframer.sv =====
// Serial packet deframer top level: parses sync, length, header, payload and checksum words.
// The status word of an accepted input word appears on the m_ channel in the next cycle.
// Throughput: one word per cycle while m_ready is not held low; the frame parser updates
// its phase and 8-bit running sum for each accepted word, and the output register is refilled as it drains.
// Reset: synchronous, active-low aresetn returns the parser to hunting the first sync
// word, clears the held header fields and empties the output register.
`default_nettype none

module serial_packet_deframer (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_rx_byte,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_frame_status,
    output logic             m_payload_valid,
    output logic [7:0]       m_payload_byte,
    output logic             m_payload_last,
    output logic [7:0]       m_frame_inst,
    output logic [7:0]       m_frame_dev_id,
    output logic [15:0]      m_frame_length
);

    // Parser state. The header fields are held from the moment they arrive until the
    // frame completes, so that they can be reported alongside the accepted status.
    spd_pkg::phase_t phase_reg, phase_next;
    logic [7:0]      length_low_reg, length_low_next;
    logic [15:0]     payload_length_reg, payload_length_next;
    logic [7:0]      held_inst_reg, held_inst_next;
    logic [7:0]      held_dev_id_reg, held_dev_id_next;
    logic [15:0]     bytes_seen_reg, bytes_seen_next;
    logic [7:0]      running_sum_reg, running_sum_next;

    // Output register contents.
    logic            m_valid_reg;
    logic [1:0]      status_reg, status_next;
    logic            pv_reg, pv_next;
    logic [7:0]      pb_reg, pb_next;
    logic            plast_reg, plast_next;
    logic [7:0]      inst_reg, inst_next;
    logic [7:0]      dev_id_reg, dev_id_next;
    logic [15:0]     length_reg, length_next;

    logic            accept_in;
    logic            frame_ok;
    logic [7:0]      len_sum;
    logic [7:0]      sum_after;
    logic [15:0]     seen_after;

    // The output register accepts a new word whenever it is empty or being drained in
    // the same cycle, so a stalled result never blocks the word arriving behind it
    // for longer than the downstream stall itself.
    assign s_ready   = !m_valid_reg || m_ready;
    assign accept_in = s_valid && s_ready;

    // The length check word is the one's complement of the low byte of the sum of the
    // two length words; likewise the payload checksum against the running sum.
    assign len_sum    = payload_length_reg[7:0] + payload_length_reg[15:8];
    assign sum_after  = running_sum_reg + s_rx_byte;
    assign seen_after = bytes_seen_reg + 16'd1;

    always_comb begin
        phase_next          = phase_reg;
        length_low_next     = length_low_reg;
        payload_length_next = payload_length_reg;
        held_inst_next      = held_inst_reg;
        held_dev_id_next    = held_dev_id_reg;
        bytes_seen_next     = bytes_seen_reg;
        running_sum_next    = running_sum_reg;
        status_next         = spd_pkg::ST_BUSY;
        pv_next             = 1'b0;
        pb_next             = 8'd0;
        plast_next          = 1'b0;
        frame_ok            = 1'b0;

        unique case (phase_reg)
            spd_pkg::PH_SYNC2: begin
                phase_next = (s_rx_byte == spd_pkg::SYNC_BYTE) ? spd_pkg::PH_LEN_LO
                                                                : spd_pkg::PH_SYNC1;
            end
            spd_pkg::PH_LEN_LO: begin
                length_low_next = s_rx_byte;
                phase_next      = spd_pkg::PH_LEN_HI;
            end
            spd_pkg::PH_LEN_HI: begin
                payload_length_next = {s_rx_byte, length_low_reg};
                phase_next          = spd_pkg::PH_LEN_CHK;
            end
            spd_pkg::PH_LEN_CHK: begin
                if (s_rx_byte == ~len_sum) begin
                    phase_next = spd_pkg::PH_INST;
                end else begin
                    phase_next  = spd_pkg::PH_SYNC1;
                    status_next = spd_pkg::ST_LEN_ERR;
                end
            end
            spd_pkg::PH_INST: begin
                held_inst_next = s_rx_byte;
                phase_next     = spd_pkg::PH_DEV_ID;
            end
            spd_pkg::PH_DEV_ID: begin
                held_dev_id_next = s_rx_byte;
                bytes_seen_next  = 16'd0;
                running_sum_next = 8'd0;
                // A zero-length frame carries no checksum word and completes here.
                if (payload_length_reg != 16'd0) begin
                    phase_next = spd_pkg::PH_PAYLOAD;
                end else begin
                    phase_next = spd_pkg::PH_SYNC1;
                    frame_ok   = 1'b1;
                end
            end
            spd_pkg::PH_PAYLOAD: begin
                running_sum_next = sum_after;
                bytes_seen_next  = seen_after;
                pv_next          = 1'b1;
                pb_next          = s_rx_byte;
                if (seen_after >= payload_length_reg) begin
                    plast_next = 1'b1;
                    phase_next = spd_pkg::PH_CSUM;
                end
            end
            spd_pkg::PH_CSUM: begin
                if (s_rx_byte == ~running_sum_reg) begin
                    frame_ok = 1'b1;
                end else begin
                    status_next = spd_pkg::ST_SUM_ERR;
                end
                phase_next      = spd_pkg::PH_SYNC1;
                bytes_seen_next = 16'd0;
            end
            default: begin
                // Hunting the first sync word; unused phase codes behave the same way.
                phase_next = (s_rx_byte == spd_pkg::SYNC_BYTE) ? spd_pkg::PH_SYNC2
                                                                : spd_pkg::PH_SYNC1;
            end
        endcase

        // Header fields are reported only with an accepted frame, and read as zero
        // otherwise.
        if (frame_ok) begin
            status_next = spd_pkg::ST_OK;
            inst_next   = held_inst_reg;
            dev_id_next = held_dev_id_next;
            length_next = payload_length_reg;
        end else begin
            inst_next   = 8'd0;
            dev_id_next = 8'd0;
            length_next = 16'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= spd_pkg::PH_SYNC1;
            length_low_reg     <= 8'd0;
            payload_length_reg <= 16'd0;
            held_inst_reg      <= 8'd0;
            held_dev_id_reg    <= 8'd0;
            bytes_seen_reg     <= 16'd0;
            running_sum_reg    <= 8'd0;
            m_valid_reg        <= 1'b0;
        end else begin
            if (accept_in) begin
                phase_reg          <= phase_next;
                length_low_reg     <= length_low_next;
                payload_length_reg <= payload_length_next;
                held_inst_reg      <= held_inst_next;
                held_dev_id_reg    <= held_dev_id_next;
                bytes_seen_reg     <= bytes_seen_next;
                running_sum_reg    <= running_sum_next;
                m_valid_reg        <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload registers need no reset; they are qualified by m_valid.
    always_ff @(posedge aclk) begin
        if (accept_in) begin
            status_reg <= status_next;
            pv_reg     <= pv_next;
            pb_reg     <= pb_next;
            plast_reg  <= plast_next;
            inst_reg   <= inst_next;
            dev_id_reg <= dev_id_next;
            length_reg <= length_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_frame_status  = status_reg;
    assign m_payload_valid = pv_reg;
    assign m_payload_byte  = pb_reg;
    assign m_payload_last  = plast_reg;
    assign m_frame_inst    = inst_reg;
    assign m_frame_dev_id  = dev_id_reg;
    assign m_frame_length  = length_reg;

endmodule : serial_packet_deframer

`default_nettype wire

// ===== rtl/spd_checker.sv =====
// Port-level assertion checker for the serial packet deframer and its bind statement.
`default_nettype none

module spd_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [1:0]  m_frame_status,
    input wire logic        m_payload_valid,
    input wire logic [7:0]  m_payload_byte,
    input wire logic        m_payload_last,
    input wire logic [7:0]  m_frame_inst,
    input wire logic [7:0]  m_frame_dev_id,
    input wire logic [15:0] m_frame_length
);

    // A reset leaves no result word pending.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result word pending after reset");

    // The last payload marker only ever comes on a payload word, with busy status.
    a_last_is_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload_last) |->
            (m_payload_valid && m_frame_status == spd_pkg::ST_BUSY))
        else $error("payload_last without a payload word");

    // Header fields read as zero unless the frame was accepted.
    a_header_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_frame_status != spd_pkg::ST_OK) |->
            (m_frame_inst == 8'd0 && m_frame_dev_id == 8'd0 && m_frame_length == 16'd0))
        else $error("header fields set on a word that is not an accepted frame");

    // A non-payload word forwards no payload data.
    a_payload_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_payload_valid) |-> (m_payload_byte == 8'd0))
        else $error("payload byte set on a non-payload word");

    // A stalled result word holds.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_frame_status)
            && $stable(m_payload_byte) && $stable(m_frame_length)))
        else $error("result word changed while stalled");

endmodule : spd_checker

bind serial_packet_deframer spd_checker u_spd_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_frame_status  (m_frame_status),
    .m_payload_valid (m_payload_valid),
    .m_payload_byte  (m_payload_byte),
    .m_payload_last  (m_payload_last),
    .m_frame_inst    (m_frame_inst),
    .m_frame_dev_id  (m_frame_dev_id),
    .m_frame_length  (m_frame_length)
);

`default_nettype wire
